// File: sv/mlbd_pkg.sv
// ----------------------------------------------------------------------------
// mlbd_pkg
// Shared types and constants of the 2x2 box-filter mip level reducer.
// ----------------------------------------------------------------------------
package mlbd_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned PAIR_W     = CHAN_W + 1;
  localparam int unsigned SUM_W      = CHAN_W + 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              level_done;
  } pix_out_t;

  // four horizontal pair sums, one per channel
  typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_sum_t;

  // per-pixel decisions made at input acceptance
  typedef struct packed {
    logic hold_left;
    logic w1;
    logic h1;
    logic store;
    logic emit;
    logic done;
  } pix_ctl_t;

endpackage

// File: sv/mlbd_ctrl.sv
// ----------------------------------------------------------------------------
// mlbd_ctrl
// Size registers, source position counters and per-pixel decisions.
// ----------------------------------------------------------------------------
module mlbd_ctrl
  import mlbd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 2048,
  parameter int unsigned CNT_W    = $clog2(MAX_SIDE),
  parameter int unsigned ADDR_W   = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  output pix_ctl_t              ctl_o,
  output logic [ADDR_W-1:0]     addr_o
);

  localparam int unsigned LINE_DEPTH = (MAX_SIDE / 2 > 0) ? MAX_SIDE / 2 : 1;
  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int unsigned EXT_W      = SIDE_W + 1;

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [CNT_W-1:0]      col_q, col_d, row_q, row_d;
  logic [SIDE_W-1:0]     w, h;
  logic [EXT_W-1:0]      col_p1, row_p1, nw, nh, ox_ext, oy_ext;
  logic [CNT_W-1:0]      ox;
  logic                  col_last, row_last, single, have_pair, ox_ok;

  // clamp sizes to 1..MAX_SIDE
  always_comb begin
    if (width_q == '0) begin
      w = SIDE_W'(1);
    end else if (32'(width_q) > MAX_SIDE) begin
      w = SIDE_W'(MAX_SIDE);
    end else begin
      w = SIDE_W'(width_q);
    end
    if (height_q == '0) begin
      h = SIDE_W'(1);
    end else if (32'(height_q) > MAX_SIDE) begin
      h = SIDE_W'(MAX_SIDE);
    end else begin
      h = SIDE_W'(height_q);
    end
  end

  always_comb begin
    col_p1   = EXT_W'(col_q) + EXT_W'(1);
    row_p1   = EXT_W'(row_q) + EXT_W'(1);
    col_last = col_p1 >= EXT_W'(w);
    row_last = row_p1 >= EXT_W'(h);
    single   = (w == SIDE_W'(1)) && (h == SIDE_W'(1));
    nw       = (w > SIDE_W'(1)) ? EXT_W'(w >> 1) : EXT_W'(1);
    nh       = (h > SIDE_W'(1)) ? EXT_W'(h >> 1) : EXT_W'(1);
    ox       = (w == SIDE_W'(1)) ? '0 : (col_q >> 1);
    ox_ext   = EXT_W'(ox);
    oy_ext   = EXT_W'(row_q >> 1);
    ox_ok    = 32'(ox) < LINE_DEPTH;
    have_pair = !single && ((w == SIDE_W'(1)) || col_q[0]);

    ctl_o.w1        = (w == SIDE_W'(1));
    ctl_o.h1        = (h == SIDE_W'(1));
    ctl_o.hold_left = !single && !ctl_o.w1 && !col_q[0] && !col_last;
    ctl_o.store     = have_pair && ox_ok && !ctl_o.h1 && !row_q[0] && !row_last;
    ctl_o.emit      = have_pair && ox_ok && (ctl_o.h1 || row_q[0]);
    ctl_o.done      = (ox_ext + EXT_W'(1) == nw) && (oy_ext + EXT_W'(1) == nh);
    addr_o          = ADDR_W'(ox);
  end

  // raster position of the next pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : CNT_W'(row_p1);
      end else begin
        col_d = CNT_W'(col_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(1);
      height_q <= CFG_DATA_W'(1);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_valid_i &&
                 (cfg_index_i == REG_SOURCE_WIDTH || cfg_index_i == REG_SOURCE_HEIGHT)) begin
      // a size write restarts the level
      if (cfg_index_i == REG_SOURCE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EXT_W'(col_q) < EXT_W'(w) && EXT_W'(row_q) < EXT_W'(h))
    else $error("position counter beyond source size");

  a_level_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && col_last && row_last && !cfg_valid_i |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after last pixel of level");

endmodule

// File: sv/mlbd_line_buf.sv
// ----------------------------------------------------------------------------
// mlbd_line_buf
// Line memory of upper-row pair sums, registered read with write bypass.
// ----------------------------------------------------------------------------
module mlbd_line_buf
  import mlbd_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  pair_sum_t         wr_data_i,
  output pair_sum_t         rd_data_o
);

  pair_sum_t mem_q [DEPTH];
  pair_sum_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one-pixel-wide source reads the entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && wr_addr_i == rd_addr_i) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/mlbd_datapath.sv
// ----------------------------------------------------------------------------
// mlbd_datapath
// Input stage, pair and block sums, and the result register.
// ----------------------------------------------------------------------------
module mlbd_datapath
  import mlbd_pkg::*;
#(
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  input  pix_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  pair_sum_t         line_rd_i,
  output logic              line_wr_en_o,
  output logic [ADDR_W-1:0] line_wr_addr_o,
  output pair_sum_t         line_wr_data_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o
);

  logic                           s1_valid_q;
  pix_in_t                        s1_px_q;
  pix_in_t                        s1_left_q;
  pix_ctl_t                       s1_ctl_q;
  logic [ADDR_W-1:0]              s1_addr_q;
  pix_in_t                        held_left_q;
  logic                           out_valid_q;
  pix_out_t                       out_data_q;
  pix_out_t                       out_data_d;
  logic                           in_accept, s1_adv, s2_free;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] px, left;
  pair_sum_t                      pair;
  logic [NUM_CHAN-1:0][SUM_W-1:0] sum;

  assign s2_free    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_ctl_q.emit || s2_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    px   = {s1_px_q.in_red, s1_px_q.in_green, s1_px_q.in_blue, s1_px_q.in_alpha};
    left = {s1_left_q.in_red, s1_left_q.in_green, s1_left_q.in_blue, s1_left_q.in_alpha};
    for (int c = 0; c < NUM_CHAN; c++) begin
      // one-pixel-wide source: edge replicate horizontally
      pair[c] = s1_ctl_q.w1 ? {px[c], 1'b0} : ({1'b0, left[c]} + {1'b0, px[c]});
      sum[c]  = s1_ctl_q.h1 ? {pair[c], 1'b0} : ({1'b0, line_rd_i[c]} + {1'b0, pair[c]});
    end
    out_data_d.out_red    = sum[3][SUM_W-1:2];
    out_data_d.out_green  = sum[2][SUM_W-1:2];
    out_data_d.out_blue   = sum[1][SUM_W-1:2];
    out_data_d.out_alpha  = sum[0][SUM_W-1:2];
    out_data_d.level_done = s1_ctl_q.done;
  end

  assign line_wr_en_o   = s1_valid_q && s1_ctl_q.store;
  assign line_wr_addr_o = s1_addr_q;
  assign line_wr_data_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      held_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (in_accept && ctl_i.hold_left) begin
        held_left_q <= in_data_i;
      end
      if (s1_adv && s1_ctl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q   <= in_data_i;
      s1_left_q <= held_left_q;
      s1_ctl_q  <= ctl_i;
      s1_addr_q <= addr_i;
    end
    if (s1_adv && s1_ctl_q.emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_store_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_ctl_q.store && s1_ctl_q.emit))
    else $error("pixel both stores and emits");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_ctl_q.emit |=> out_valid_q)
    else $error("emitted pixel lost at result register");

endmodule

// File: sv/mip_level_box_downsample_unit.sv
// ----------------------------------------------------------------------------
// mip_level_box_downsample_unit
// 2x2 box-filter reducer from one RGBA8 mip level to the next.
// ----------------------------------------------------------------------------
// Source pixels enter on the in channel in raster order, one transaction per
// pixel; reduced pixels leave on the out channel with level_done set on the
// last one of the level. Source width and height are written on the cfg
// channel (index 0 width, index 1 height); the user must write them only while the
// block is idle, which the block itself does not enforce. Each write restarts the
// level. cfg_ready_o is always high. Throughput is one pixel per cycle while the
// receiver keeps up. After the pixel that completes its 2x2 block is accepted, the
// reduced pixel is formed in the input stage, where the line memory read returns,
// and then held in the result register. For a source more than one pixel wide and
// high, only every second pixel of every second row produces a result. When the
// receiver stalls, the result register holds and the input stage keeps accepting
// until a second result is waiting, then in_ready_o drops. Reset sets both sizes
// to one and the position to the level start. The line memory is not cleared; an
// entry is always written by the upper row before the lower row reads it.
// ----------------------------------------------------------------------------
module mip_level_box_downsample_unit
  import mlbd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LINE_DEPTH = (MAX_SIDE / 2 > 0) ? MAX_SIDE / 2 : 1;
  localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_SIDE);

  pix_ctl_t          ctl;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en, in_accept;
  pair_sum_t         rd_data, wr_data;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  mlbd_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .CNT_W    (CNT_W),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .ctl_o       (ctl),
    .addr_o      (rd_addr)
  );

  mlbd_line_buf #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  mlbd_datapath #(
    .ADDR_W (ADDR_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .ctl_i          (ctl),
    .addr_i         (rd_addr),
    .line_rd_i      (rd_data),
    .line_wr_en_o   (wr_en),
    .line_wr_addr_o (wr_addr),
    .line_wr_data_o (wr_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule
